### rtl/core/spwm_pkg.sv
// ----------------------------------------------------------------------------
// Sine PWM package
// Shared types, register indexes, action codes and reset constants for the
// half-wave sinusoidal PWM generator.
// ----------------------------------------------------------------------------
package spwm_pkg;

    // Default build constants.
    localparam int DEF_TABLE_DEPTH = 128;
    localparam int DEF_COUNT_WIDTH = 16;

    // Field widths fixed by the interface.
    localparam int DUTY_W  = 16;
    localparam int STEP_W  = 8;
    localparam int INDEX_W = 7;
    localparam int CFG_W   = 16;

    // Reset values of the configuration registers, derived from the timer
    // clock, the output frequency and the steps in one full sine wave.
    localparam int CLOCK_HZ       = 16000000;
    localparam int OUTPUT_HZ      = 50;
    localparam int STEPS_PER_WAVE = 200;
    localparam logic [15:0] TOP_RESET =
        16'(CLOCK_HZ / (OUTPUT_HZ * STEPS_PER_WAVE));
    localparam logic [7:0] HALF_STEPS_RESET = 8'(STEPS_PER_WAVE / 2);

    // Configuration register indexes.
    localparam logic REG_TOP        = 1'b0;
    localparam logic REG_HALF_STEPS = 1'b1;

    // Input item action codes.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Input item.
    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] entry_index;
        logic [DUTY_W-1:0]  entry_value;
    } spwm_in_t;

    // Result item.
    typedef struct packed {
        logic              pwm_a;
        logic              pwm_b;
        logic              driving_b;
        logic [STEP_W-1:0] step_now;
    } spwm_out_t;

endpackage

### rtl/core/sine_pwm_half_wave_generator.sv
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register frees s_ready whenever
// it is empty or being taken in the same cycle.
// Reset (aresetn low, synchronous): timer, duties, step index, flip and leg
// clear, top and half_steps return to 1600 and 100; table contents are kept.
// ----------------------------------------------------------------------------
// Sine PWM half-wave generator
// Two-leg inverter SPWM: a timer with programmable top, a half-sine duty
// table in RAM, and a driven leg that alternates on every half wave.
// ----------------------------------------------------------------------------
module sine_pwm_half_wave_generator #(
    parameter int TABLE_DEPTH = spwm_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = spwm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [spwm_pkg::CFG_W-1:0]     cfg_wdata,
    // Input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  spwm_pkg::spwm_in_t             s_data,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output spwm_pkg::spwm_out_t            m_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (COUNT_WIDTH > spwm_pkg::DUTY_W) ? COUNT_WIDTH : spwm_pkg::DUTY_W;
    localparam int SW    = spwm_pkg::STEP_W;
    localparam int DW    = spwm_pkg::DUTY_W;

    // Configuration registers.
    logic [15:0]  top_reg;
    logic [7:0]   half_steps_reg;

    // Waveform state.
    logic [CW-1:0] timer_reg,       timer_next;
    logic [DW-1:0] duty_active_reg, duty_active_next;
    logic          buf_valid_reg,   buf_valid_next;
    logic [SW-1:0] step_reg,        step_next;
    logic          flip_reg,        flip_next;
    logic          leg_b_reg,       leg_b_next;

    // Result register.
    logic                m_valid_reg;
    spwm_pkg::spwm_out_t m_data_reg, m_data_next;

    logic          accept;
    logic          tick;
    logic          load;
    logic          wrap;
    logic          wrap_tick;
    logic          load_in_range;
    logic          rd_in_range;
    logic [SW-1:0] rd_index;
    logic          leg_wrap;
    logic          flip_wrap;
    logic [DW-1:0] table_rdata;
    logic          high;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign tick      = accept && (s_data.action == spwm_pkg::ACT_TICK);
    assign load      = accept && (s_data.action == spwm_pkg::ACT_LOAD);
    assign wrap      = CMP_W'(timer_reg) >= CMP_W'(top_reg);
    assign wrap_tick = tick && wrap;

    // Loads beyond the table depth are dropped.
    assign load_in_range = 32'(s_data.entry_index) < TABLE_DEPTH;

    // Overflow step: flip the leg if armed, else wrap the index at the half wave.
    always_comb begin
        leg_wrap  = leg_b_reg;
        flip_wrap = flip_reg;
        rd_index  = step_reg;
        if (flip_reg) begin
            leg_wrap  = !leg_b_reg;
            flip_wrap = 1'b0;
        end else if (step_reg >= half_steps_reg) begin
            rd_index  = '0;
            flip_wrap = 1'b1;
        end
    end

    assign rd_in_range = 32'(rd_index) < TABLE_DEPTH;

    // Half-sine duty table; the entry read at one wrap is applied at the next.
    spwm_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (load && load_in_range),
        .waddr (AW'(s_data.entry_index)),
        .wdata (s_data.entry_value),
        .re    (wrap_tick),
        .raddr (AW'(rd_index)),
        .rdata (table_rdata)
    );

    // Next state for a tick.
    always_comb begin
        timer_next       = timer_reg;
        duty_active_next = duty_active_reg;
        buf_valid_next   = buf_valid_reg;
        step_next        = step_reg;
        flip_next        = flip_reg;
        leg_b_next       = leg_b_reg;
        if (tick) begin
            if (wrap) begin
                timer_next       = '0;
                duty_active_next = buf_valid_reg ? table_rdata : '0;
                buf_valid_next   = rd_in_range;
                step_next        = rd_index + SW'(1);
                flip_next        = flip_wrap;
                leg_b_next       = leg_wrap;
            end else begin
                timer_next = timer_reg + CW'(1);
            end
        end
    end

    // Pin levels from the state after this item.
    assign high = (timer_next == '0) || (CMP_W'(timer_next) < CMP_W'(duty_active_next));

    always_comb begin
        m_data_next.pwm_a     = !leg_b_next && high;
        m_data_next.pwm_b     = leg_b_next && high;
        m_data_next.driving_b = leg_b_next;
        m_data_next.step_now  = step_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg        <= spwm_pkg::TOP_RESET;
            half_steps_reg <= spwm_pkg::HALF_STEPS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                spwm_pkg::REG_TOP: begin
                    top_reg <= cfg_wdata;
                end
                spwm_pkg::REG_HALF_STEPS: begin
                    half_steps_reg <= cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Waveform state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg       <= '0;
            duty_active_reg <= '0;
            buf_valid_reg   <= 1'b0;
            step_reg        <= '0;
            flip_reg        <= 1'b0;
            leg_b_reg       <= 1'b0;
        end else begin
            timer_reg       <= timer_next;
            duty_active_reg <= duty_active_next;
            buf_valid_reg   <= buf_valid_next;
            step_reg        <= step_next;
            flip_reg        <= flip_next;
            leg_b_reg       <= leg_b_next;
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // The driven leg changes only on a wrap with a flip armed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (leg_b_reg != $past(leg_b_reg)))
            |-> ($past(wrap_tick) && $past(flip_reg)))
        else $error("leg changed without an armed flip at a wrap");

    // A wrap with a flip armed always disarms it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wrap_tick && flip_reg) |=> !flip_reg)
        else $error("flip stayed armed after it was taken");

    // The active duty changes only at a wrap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (duty_active_reg != $past(duty_active_reg)))
            |-> $past(wrap_tick))
        else $error("active duty changed outside a wrap");
`endif

endmodule

### rtl/core/spwm_ram.sv
// ----------------------------------------------------------------------------
// Sine PWM table RAM
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module spwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
